[hw/rtl/art_pkg.sv]
// Shared types and constants for the address region table.
// Holds the transaction structs, command and status codes, and the scan states.
// No dependencies.
package art_pkg;

    // Default number of stored ranges.
    localparam int ART_ENTRIES = 16;

    // Command codes. The unused fourth code behaves as a load lookup.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_CREATE = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_LOAD_HIT   = 3'd0;
    localparam logic [2:0] STAT_LOAD_MISS  = 3'd1;
    localparam logic [2:0] STAT_STORE_HIT  = 3'd2;
    localparam logic [2:0] STAT_STORE_MISS = 3'd3;
    localparam logic [2:0] STAT_CREATED    = 3'd4;
    localparam logic [2:0] STAT_OVERLAP    = 3'd5;
    localparam logic [2:0] STAT_FULL       = 3'd6;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] address;
        logic signed [31:0] range_end;
        logic [15:0]        region_id;
    } art_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] region_out;
    } art_rsp_t;

    // One stored range as it sits in the table memory.
    typedef struct packed {
        logic signed [31:0] start_addr;
        logic signed [31:0] end_addr;
        logic [15:0]        region;
    } art_entry_t;

    localparam int ENTRY_W = $bits(art_entry_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } art_state_t;

endpackage

[hw/rtl/art_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the range table of the address region table. No dependencies.
module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/address_region_table.sv]
// Address region table: top level with the scan sequencer and response register.
// Depends on art_pkg and art_ram.
//
// The block keeps up to ENTRIES inclusive address ranges in one synchronous
// memory, each tagged with a 16-bit region number. Every request transaction
// walks the stored ranges in insertion order with a single comparator set, one
// memory read per cycle, and keeps the best hit: the lowest region number, and
// among equal numbers the range inserted first. A load or store lookup reports
// the region whose range holds the address, or a miss with region 0. A create
// stores the new range only when it overlaps no stored range; otherwise it
// reports the conflicting region, and with a full table and no conflict it
// reports table full and stores nothing. Ranges are never removed. One request
// is in flight at a time: a request occupies the block while it reads every
// stored range, or goes straight to its response while the table is empty; the
// memory read port delivers one stored range per cycle. The response sits in
// an output register, so the next request is taken while a finished response
// still waits for the downstream side. The table needs no clearing after
// reset: only the first count entries, all written by earlier creates, are
// ever read.
module address_region_table #(
    parameter int ENTRIES = art_pkg::ART_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  art_pkg::art_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output art_pkg::art_rsp_t rsp
);

    import art_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // Sequencer state.
    art_state_t state_reg, state_next;

    // Latched request payload.
    logic [1:0]         cmd_reg;
    logic signed [31:0] addr_reg;
    logic signed [31:0] end_reg;
    logic [15:0]        rid_reg;

    // Table fill and scan bookkeeping.
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          issue_reg, issue_next;
    logic          pend_reg, pend_next;
    logic          found_reg, found_next;
    logic [15:0]   best_reg, best_next;

    // Response register.
    art_rsp_t rsp_reg, rsp_next;
    logic     rsp_valid_reg, rsp_valid_next;

    // Memory interface.
    logic          ram_we;
    logic          ram_re;
    art_entry_t    ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    art_entry_t    cur;

    logic accept;
    logic out_load;
    logic is_create;
    logic hit_create;
    logic hit_lookup;
    logic take;
    logic last_issue;
    logic table_full;

    art_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign cur        = art_entry_t'(ram_rdata);
    assign is_create  = (cmd_reg == CMD_CREATE);
    assign table_full = (count_reg == CW'(ENTRIES));

    // A create conflicts when either end of the stored range falls inside the
    // new one, or the new range lies inside the stored one.
    assign hit_create = (addr_reg <= cur.start_addr && end_reg >= cur.start_addr) ||
                        (addr_reg <= cur.end_addr   && end_reg >= cur.end_addr) ||
                        (addr_reg >= cur.start_addr && end_reg <= cur.end_addr);
    assign hit_lookup = (addr_reg >= cur.start_addr) && (addr_reg <= cur.end_addr);

    // Strict compare keeps the earliest entry among equal region numbers.
    assign take = pend_reg && (is_create ? hit_create : hit_lookup) &&
                  (!found_reg || (cur.region < best_reg));

    assign last_issue = ((CW'(rd_idx_reg) + CW'(1)) == count_reg);
    assign ram_re     = issue_reg;

    assign ram_wdata.start_addr = addr_reg;
    assign ram_wdata.end_addr   = end_reg;
    assign ram_wdata.region     = rid_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        found_next     = found_reg;
        best_next      = best_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        out_load       = 1'b0;

        if (take)
        begin
            found_next = 1'b1;
            best_next  = cur.region;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    found_next  = 1'b0;
                    rd_idx_next = '0;
                    if (count_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        issue_next = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue_reg)
                begin
                    pend_next   = 1'b1;
                    rd_idx_next = rd_idx_reg + AW'(1);
                    if (last_issue)
                    begin
                        issue_next = 1'b0;
                    end
                end
                else if (pend_reg)
                begin
                    // Last stored range is being compared this cycle.
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    out_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (is_create)
                    begin
                        priority if (found_reg)
                        begin
                            rsp_next.status     = STAT_OVERLAP;
                            rsp_next.region_out = best_reg;
                        end
                        else if (table_full)
                        begin
                            rsp_next.status     = STAT_FULL;
                            rsp_next.region_out = rid_reg;
                        end
                        else
                        begin
                            rsp_next.status     = STAT_CREATED;
                            rsp_next.region_out = rid_reg;
                            ram_we              = 1'b1;
                            count_next          = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        if (cmd_reg == CMD_STORE)
                        begin
                            rsp_next.status = found_reg ? STAT_STORE_HIT : STAT_STORE_MISS;
                        end
                        else
                        begin
                            rsp_next.status = found_reg ? STAT_LOAD_HIT : STAT_LOAD_MISS;
                        end
                        rsp_next.region_out = found_reg ? best_reg : 16'd0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= req.cmd;
            addr_reg <= req.address;
            end_reg  <= req.range_end;
            rid_reg  <= req.region_id;
        end
        best_reg <= best_next;
        rsp_reg  <= rsp_next;
    end

`ifndef SYNTHESIS
    // The fill count can never pass the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("region table count exceeds its size");

    // A successful create grows the table by exactly one range.
    a_create_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && rsp_next.status == STAT_CREATED) |=>
            (count_reg == $past(count_reg) + CW'(1)))
        else $error("create response without table growth");

    // Table full is only reported when every entry is in use.
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && rsp_next.status == STAT_FULL) |-> table_full)
        else $error("table full reported with free entries");

    // Memory data is only compared while a scan is in progress.
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_SCAN))
        else $error("read data pending outside of a scan");
`endif

endmodule

[tb/address_region_table_checker.sv]
`timescale 1ns / 1ps
// Checker for the address region table: watches both channels, predicts every response
// from its own copy of the range table and compares it with what the block returns.
// Depends on art_pkg.
module address_region_table_checker #(
    parameter int ENTRIES = art_pkg::ART_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  art_pkg::art_req_t req,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  art_pkg::art_rsp_t rsp,
    output int                mismatch_count,
    output int                pending_count
);
    import art_pkg::*;

    logic signed [31:0] span_lo [ENTRIES];
    logic signed [31:0] span_hi [ENTRIES];
    logic [15:0]        span_region [ENTRIES];
    int                 span_used;

    art_rsp_t pending_answers [$];
    int       faults;

    // Works out the response to one request and updates the table on a create.
    function automatic art_rsp_t resolve_request(input art_req_t r);
        art_rsp_t           res;
        logic               found;
        logic               hit;
        logic [15:0]        best;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] s;
        logic signed [31:0] e;
        int                 i;
        found = 1'b0;
        best  = '0;
        a     = r.address;
        b     = r.range_end;
        for (i = 0; i < span_used; i++)
        begin
            s = span_lo[i];
            e = span_hi[i];
            if (r.cmd == CMD_CREATE)
                hit = (a <= s && b >= s) || (a <= e && b >= e) || (a >= s && b <= e);
            else
                hit = a >= s && a <= e;
            // Lowest region wins; a tie keeps the earlier entry.
            if (hit && (!found || span_region[i] < best))
            begin
                best  = span_region[i];
                found = 1'b1;
            end
        end
        if (r.cmd == CMD_CREATE)
        begin
            if (found)
            begin
                res.status     = STAT_OVERLAP;
                res.region_out = best;
            end
            else if (span_used >= ENTRIES)
            begin
                res.status     = STAT_FULL;
                res.region_out = r.region_id;
            end
            else
            begin
                span_lo[span_used]     = a;
                span_hi[span_used]     = b;
                span_region[span_used] = r.region_id;
                span_used++;
                res.status     = STAT_CREATED;
                res.region_out = r.region_id;
            end
        end
        else
        begin
            if (r.cmd == CMD_STORE)
                res.status = found ? STAT_STORE_HIT : STAT_STORE_MISS;
            else
                res.status = found ? STAT_LOAD_HIT : STAT_LOAD_MISS;
            res.region_out = found ? best : 16'd0;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin : watch
        art_rsp_t want;
        if (!rst_n)
        begin
            span_used = 0;
            faults    = 0;
            pending_answers.delete();
        end
        else
        begin
            // A response never belongs to the request accepted at the same edge.
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_answers.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: unexpected response status %0d region %0d",
                                 $time, rsp.status, rsp.region_out);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (rsp.status !== want.status || rsp.region_out !== want.region_out)
                    begin
                        faults++;
                        if (faults <= 10)
                            $display({"%0t: mismatch: expected status %0d region %0d,",
                                      " got status %0d region %0d"},
                                     $time, want.status, want.region_out,
                                     rsp.status, rsp.region_out);
                    end
                end
            end
            // New predictions join the tail of the queue.
            if (req_valid && !req_stall)
                pending_answers = {pending_answers, resolve_request(req)};
        end
        mismatch_count <= faults;
        pending_count  <= pending_answers.size();
    end

endmodule

[tb/address_region_table_test.sv]
`timescale 1ns / 1ps
// Top of the address region table testbench: clock, reset, request and response
// drivers, and the final verdict. Depends on art_pkg, address_region_table and
// address_region_table_checker.
module address_region_table_test;
    import art_pkg::*;

    // The fourth command code has no name in the package; the block treats it as a load.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 900;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    art_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    art_rsp_t rsp;
    int       mismatch_count;
    int       pending_count;

    // Set by the request driver to steer the response side: hold_go asks for one
    // long hold-off, rsp_calm asks for a stretch with no stalls at all.
    logic hold_go;
    logic rsp_calm;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    address_region_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    address_region_table_checker #(
        .ENTRIES (ART_ENTRIES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    function automatic art_req_t make_req(input logic [1:0] cmd,
                                          input logic signed [31:0] lo,
                                          input logic signed [31:0] hi,
                                          input logic [15:0] region);
        art_req_t r;
        r.cmd       = cmd;
        r.address   = lo;
        r.range_end = hi;
        r.region_id = region;
        return r;
    endfunction

    // Most addresses land in three narrow windows: around zero and at both ends of
    // the signed range, so that stored ranges get hit and the signed compare is
    // exercised where it wraps. The rest are fully random.
    function automatic logic signed [31:0] pick_address();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return $urandom;
        else if (roll < 60)
            return 32'($urandom_range(0, 1023)) - 32'd512;
        else if (roll < 80)
            return 32'h7FFF_FFFF - 32'($urandom_range(0, 511));
        else
            return 32'h8000_0000 + 32'($urandom_range(0, 511));
    endfunction

    // Creates are rare early on, so lookups see the table while it is only partly
    // filled; later they are common, and once the table is full they come back as
    // overlap or table full. Region numbers are often small so that ties occur.
    function automatic art_req_t random_request(input int idx);
        art_req_t r;
        int       roll;
        int       create_pct;
        create_pct = (idx < 300) ? 8 : 35;
        roll       = $urandom_range(0, 99);
        r.address  = pick_address();
        r.region_id = $urandom_range(0, 1) ? 16'($urandom_range(0, 7))
                                           : 16'($urandom_range(0, 65535));
        if (roll < create_pct) begin
            r.cmd = CMD_CREATE;
            roll  = $urandom_range(0, 99);
            if (roll < 75)
                r.range_end = r.address + 32'($urandom_range(0, 120));
            else if (roll < 87)
                r.range_end = r.address - 32'($urandom_range(1, 100));
            else
                r.range_end = $urandom;
        end else begin
            if (roll < create_pct + 5)
                r.cmd = CMD_UNUSED;
            else
                r.cmd = $urandom_range(0, 1) ? CMD_STORE : CMD_LOAD;
            r.range_end = $urandom;
        end
        return r;
    endfunction

    // Presents one request transaction and returns at the edge that accepts it.
    // A random gap may come first; valid is only dropped for the gap and never in
    // the step that raises it again.
    task automatic offer(input art_req_t item, input bit may_idle);
        int gap;
        gap = 0;
        if (may_idle && $urandom_range(0, 99) < 24)
            gap = $urandom_range(1, 40);
        while (gap > 0) begin
            req_valid <= 1'b0;
            @(posedge clk);
            gap--;
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Drops valid and waits until every predicted response has come back.
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    // Request side: reset, a directed opening, then the random body with its
    // pressure points, then the drain and the verdict.
    initial begin : request_side
        int i;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        hold_go   <= 1'b0;
        rsp_calm  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Lookups on the empty table, with the ignored fields at their extremes.
        offer(make_req(CMD_LOAD, 32'd0, 32'd0, 16'd0), 1'b1);
        offer(make_req(CMD_STORE, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF), 1'b1);
        offer(make_req(CMD_UNUSED, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000), 1'b1);
        // One range, then hits on both bounds and in the middle, and misses just outside them.
        offer(make_req(CMD_CREATE, 32'd100, 32'd200, 16'd5), 1'b1);
        offer(make_req(CMD_LOAD, 32'd100, 32'd0, 16'd0), 1'b1);
        offer(make_req(CMD_LOAD, 32'd200, 32'd0, 16'd0), 1'b1);
        offer(make_req(CMD_STORE, 32'd99, 32'd0, 16'd0), 1'b1);
        offer(make_req(CMD_STORE, 32'd201, 32'd0, 16'd0), 1'b1);
        offer(make_req(CMD_UNUSED, 32'd150, 32'd0, 16'd0), 1'b1);
        offer(make_req(CMD_STORE, 32'd150, 32'd0, 16'd0), 1'b1);
        // Each way a create can conflict: touching the start, touching the end,
        // lying inside, and covering the stored range.
        offer(make_req(CMD_CREATE, 32'd50, 32'd100, 16'd9), 1'b1);
        offer(make_req(CMD_CREATE, 32'd200, 32'd300, 16'd9), 1'b1);
        offer(make_req(CMD_CREATE, 32'd120, 32'd130, 16'd1), 1'b1);
        offer(make_req(CMD_CREATE, 32'd0, 32'd1000, 16'd9), 1'b1);
        // A reversed range is stored but can never be hit by a lookup.
        offer(make_req(CMD_CREATE, 32'd500, 32'd400, 16'd7), 1'b1);
        offer(make_req(CMD_LOAD, 32'd450, 32'd0, 16'd0), 1'b1);
        offer(make_req(CMD_LOAD, 32'd500, 32'd0, 16'd0), 1'b1);
        // Single-address ranges at both ends of the signed range.
        offer(make_req(CMD_CREATE, 32'h8000_0000, 32'h8000_0000, 16'h0000), 1'b1);
        offer(make_req(CMD_CREATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF), 1'b1);
        offer(make_req(CMD_LOAD, 32'h8000_0000, 32'd0, 16'd0), 1'b1);
        offer(make_req(CMD_STORE, 32'h7FFF_FFFF, 32'd0, 16'd0), 1'b1);
        // Several conflicts at once: the lowest region number must be reported.
        offer(make_req(CMD_CREATE, 32'd300, 32'd310, 16'd2), 1'b1);
        offer(make_req(CMD_CREATE, 32'd320, 32'd330, 16'd2), 1'b1);
        offer(make_req(CMD_CREATE, 32'd250, 32'd350, 16'd3), 1'b1);
        offer(make_req(CMD_CREATE, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1), 1'b1);

        for (i = 0; i < RANDOM_REQUESTS; i++) begin
            // Ask the response side for its long hold-off while requests keep
            // coming, so that the output register fills and the input stalls.
            if (i == 300)
                hold_go <= 1'b1;
            // Once, let the block run completely dry before going on.
            if (i == 450)
                drain();
            rsp_calm <= (i >= 600 && i < 750);
            // Requests 150 to 299 go back to back with no gaps.
            offer(random_request(i), !(i >= 150 && i < 300));
        end

        drain();
        // Leave room for stray responses.
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Response side: random stalls about a quarter of the time, one solid long
    // hold-off when asked, and no stalls while rsp_calm is set.
    initial begin : response_side
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_go && !hold_done) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                rsp_stall <= 1'b1;
                hold_left--;
            end else if (rsp_calm) begin
                rsp_stall <= 1'b0;
            end else begin
                rsp_stall <= ($urandom_range(0, 99) < 24);
            end
        end
    end

    // Backstop in case the block stops answering.
    initial begin : watchdog
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[address_region_table.f]
hw/rtl/art_pkg.sv
hw/rtl/art_ram.sv
hw/rtl/address_region_table.sv
tb/address_region_table_checker.sv
tb/address_region_table_test.sv
